// ===== src/tse_pkg.sv =====
// Shared types, constants and register codes for the timestamp estimator.
// Used by the core and by its serial multiply-divide unit; depends on nothing.
`default_nettype none

package tse_pkg;

  // Width in which system and local times are kept.
  localparam int TIME_WIDTH = 64;
  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef logic [63:0] ticks_t;
  localparam ticks_t TICKS_NONE = '1;
  localparam ticks_t EST_MAX    = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam logic [31:0] US_PER_S = 32'd1_000_000;

  localparam logic OP_SYNC  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CLOCK_FREQ   = 2'd0;
  localparam cfg_idx_t CFG_EARLY_MARGIN = 2'd1;
  localparam cfg_idx_t CFG_LATE_LIMIT   = 2'd2;

  localparam logic [29:0] FREQ_RESET  = 30'd62_500_000;
  localparam logic [31:0] EARLY_RESET = 32'd10_000;
  localparam logic [31:0] LATE_RESET  = 32'd1_000_000;

  // Serial multiply-divide: 64-bit operand times 32-bit factor, over a 32-bit divisor.
  localparam int MD_A_W       = 64;
  localparam int MD_B_W       = 32;
  localparam int MD_PROD_W    = MD_A_W + MD_B_W;
  localparam int MD_MUL_STEPS = MD_B_W;
  localparam int MD_DIV_STEPS = MD_PROD_W;
  localparam int MD_CNT_W     = $clog2(MD_DIV_STEPS);

  typedef struct packed {
    logic              start;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
    logic [MD_B_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [MD_A_W-1:0] q;
  } md_rsp_t;

endpackage

`default_nettype wire

// ===== src/tse_muldiv.sv =====
// Bit-serial unit computing floor(a * b / d), saturated to all ones above 64 bits.
// Depends on tse_pkg for the request and response structs and the step counts.
`default_nettype none

module tse_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  tse_pkg::md_req_t req,
  output tse_pkg::md_rsp_t rsp
);
  import tse_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t           state;
  logic [MD_CNT_W-1:0] cnt;
  logic                done;
  logic [MD_A_W-1:0]   a_reg;
  logic [MD_B_W-1:0]   b_reg;
  logic [MD_B_W-1:0]   d_reg;
  logic [MD_PROD_W-1:0] acc;
  logic [MD_B_W-1:0]   rem;
  logic [MD_B_W:0]     trial;
  logic                trial_ge;

  // One restoring-division step: bring down the next dividend bit.
  assign trial    = {rem, acc[MD_PROD_W-1]};
  assign trial_ge = trial >= {1'b0, d_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (req.start) begin
            cnt   <= '0;
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (cnt == MD_CNT_W'(MD_MUL_STEPS - 1)) begin
            cnt   <= '0;
            state <= MD_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        MD_DIV: begin
          if (cnt == MD_CNT_W'(MD_DIV_STEPS - 1)) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= MD_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  // The product builds up MSB first in acc; the division then shifts the
  // quotient into acc from the right as the dividend leaves on the left.
  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (req.start) begin
          a_reg <= req.a;
          b_reg <= req.b;
          d_reg <= req.d;
          acc   <= '0;
          rem   <= '0;
        end
      end
      MD_MUL: begin
        acc   <= {acc[MD_PROD_W-2:0], 1'b0}
                 + (b_reg[MD_B_W-1] ? MD_PROD_W'(a_reg) : '0);
        b_reg <= {b_reg[MD_B_W-2:0], 1'b0};
      end
      MD_DIV: begin
        rem <= trial_ge ? MD_B_W'(trial - {1'b0, d_reg}) : trial[MD_B_W-1:0];
        acc <= {acc[MD_PROD_W-2:0], trial_ge};
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.q    = (|acc[MD_PROD_W-1:MD_A_W]) ? '1 : acc[MD_A_W-1:0];

endmodule

`default_nettype wire

// ===== src/timesync_timestamp_estimator_core.sv =====
// Top level of the timestamp estimator: sequencer, state and result register.
// Depends on tse_pkg and on the serial multiply-divide unit tse_muldiv.
`default_nettype none

// The core keeps the newest sync point (tick count plus the system time it
// was taken at) and extrapolates the tick count at a local time as
// base ticks + floor(elapsed_us * clock_freq_hz / 1000000). A sync request
// (opcode 0) stores a newer sync point, raises early or late warnings
// against the configured margins, and moves the stored estimate forward,
// never backwards. A query request (opcode 1) returns the estimate at its
// own local time and the whole microseconds left until target_ticks. Every
// request returns exactly one result. All products and quotients are exact
// and go through one shared bit-serial multiply-divide unit that first
// forms the 96-bit product and then the quotient. A sync request uses the
// unit only when its local time is past the sync time; a query uses it for
// the extrapolation and again for the wait only while the target is still
// ahead; without a sync point or an estimate the unit is not used. The next
// request can be taken as soon as the result is presented. Requests are
// worked on one at a time: in_ready is high whenever the sequencer is idle,
// even while a finished result still waits on the output port. Configuration
// writes are always taken and should only be issued while no request is in
// flight. The block needs no clearing pass after reset.
module timesync_timestamp_estimator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [63:0]                   sync_ticks,
  input  logic [63:0]                   sync_time_us,
  input  logic [63:0]                   now_us,
  input  logic [63:0]                   target_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          estimate_valid,
  output logic [63:0]                   estimate_ticks,
  output logic [63:0]                   wait_us,
  output logic                          updated,
  output logic                          early_warn,
  output logic [63:0]                   early_by_us,
  output logic                          late_warn,
  output logic [63:0]                   late_by_us
);
  import tse_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE        = 13'b0000000000001,
    ST_SYNC_UPD    = 13'b0000000000010,
    ST_SYNC_DIFF   = 13'b0000000000100,
    ST_SYNC_WARN   = 13'b0000000001000,
    ST_SYNC_MUL    = 13'b0000000010000,
    ST_SYNC_ADD    = 13'b0000000100000,
    ST_SYNC_CMP    = 13'b0000001000000,
    ST_QRY_ELAPSED = 13'b0000010000000,
    ST_QRY_MUL     = 13'b0000100000000,
    ST_QRY_ADD     = 13'b0001000000000,
    ST_QRY_TGT     = 13'b0010000000000,
    ST_QRY_DIV     = 13'b0100000000000,
    ST_FINISH      = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic   estimate_valid;
    ticks_t estimate_ticks;
    ticks_t wait_us;
    logic   updated;
    logic   early_warn;
    ticks_t early_by_us;
    logic   late_warn;
    ticks_t late_by_us;
  } result_t;

  // Adds an increment to a tick estimate, saturating one below the
  // "no estimate" pattern.
  function automatic ticks_t add_est(ticks_t base, ticks_t inc);
    logic [64:0] s;
    s = {1'b0, base} + {1'b0, inc};
    if (s[64] || s[63:0] == TICKS_NONE) begin
      return EST_MAX;
    end
    return s[63:0];
  endfunction

  state_t state;

  // Configuration registers.
  logic [29:0] clock_freq_hz;
  logic [31:0] early_margin_us;
  logic [31:0] late_limit_us;

  // Sync point and stored estimate.
  ticks_t latest_sync_ticks;
  time_t  latest_sync_time;
  ticks_t estimate_base_ticks;
  time_t  estimate_base_time;

  // Request being worked on.
  logic   op_q;
  ticks_t sticks_q;
  time_t  stime_q;
  time_t  now_q;
  ticks_t target_q;

  // Working values and the result under construction.
  logic   sync_ahead;
  logic   local_ahead;
  time_t  lead_sync;
  time_t  lead_local;
  ticks_t est_work;
  ticks_t res_wait;
  logic   res_updated;
  logic   res_early_warn;
  ticks_t res_early_by;
  logic   res_late_warn;
  ticks_t res_late_by;

  result_t out_res;

  logic [MD_B_W-1:0]   freq_eff;
  logic [TIME_WIDTH:0] sub_sync_lead;
  logic [TIME_WIDTH:0] sub_local_lead;
  logic [TIME_WIDTH:0] sub_elapsed;
  logic [64:0]         sub_target;
  logic                sticks_newer;
  logic                est_newer;
  logic                out_free;
  ticks_t              fin_ticks;
  md_req_t             md_req;
  md_rsp_t             md_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // A frequency of zero is treated as one hertz.
  assign freq_eff = (clock_freq_hz == '0) ? MD_B_W'(1) : MD_B_W'(clock_freq_hz);

  // The borrow bit of each difference tells which time is ahead.
  assign sub_sync_lead  = {1'b0, latest_sync_time} - {1'b0, now_q};
  assign sub_local_lead = {1'b0, now_q} - {1'b0, latest_sync_time};
  assign sub_elapsed    = {1'b0, now_q} - {1'b0, estimate_base_time};
  assign sub_target     = {1'b0, target_q} - {1'b0, est_work};

  // An all-ones tick count means "no sync point" and never wins.
  assign sticks_newer = (sticks_q != TICKS_NONE)
                        && (latest_sync_ticks == TICKS_NONE || sticks_q > latest_sync_ticks);
  assign est_newer    = (estimate_base_ticks == TICKS_NONE) || (est_work >= estimate_base_ticks);

  // Sync results report the stored base; queries report the extrapolation.
  assign fin_ticks = (op_q == OP_SYNC) ? estimate_base_ticks : est_work;

  // Three uses of the shared multiply-divide unit: forward extrapolation
  // after a sync, extrapolation for a query, and the wait until the target.
  always_comb begin
    md_req.start = 1'b0;
    md_req.a     = '0;
    md_req.b     = freq_eff;
    md_req.d     = US_PER_S;
    unique case (state)
      ST_SYNC_WARN: begin
        md_req.start = local_ahead;
        md_req.a     = MD_A_W'(lead_local);
      end
      ST_QRY_ELAPSED: begin
        md_req.start = (estimate_base_ticks != TICKS_NONE);
        md_req.a     = sub_elapsed[TIME_WIDTH] ? '0 : MD_A_W'(sub_elapsed[TIME_WIDTH-1:0]);
      end
      ST_QRY_TGT: begin
        md_req.start = !sub_target[64] && (sub_target[63:0] != '0);
        md_req.a     = sub_target[63:0];
        md_req.b     = US_PER_S;
        md_req.d     = freq_eff;
      end
      default: ;
    endcase
  end

  tse_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Sequencer, configuration and the estimator's own state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      out_valid           <= 1'b0;
      clock_freq_hz       <= FREQ_RESET;
      early_margin_us     <= EARLY_RESET;
      late_limit_us       <= LATE_RESET;
      latest_sync_ticks   <= TICKS_NONE;
      latest_sync_time    <= '0;
      estimate_base_ticks <= TICKS_NONE;
      estimate_base_time  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CLOCK_FREQ:   clock_freq_hz   <= cfg_data[29:0];
          CFG_EARLY_MARGIN: early_margin_us <= cfg_data;
          CFG_LATE_LIMIT:   late_limit_us   <= cfg_data;
          default: ;
        endcase
      end

      // In the finishing state the valid flag is set below instead.
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state <= (opcode == OP_SYNC) ? ST_SYNC_UPD : ST_QRY_ELAPSED;
          end
        end
        ST_SYNC_UPD: begin
          if (sticks_newer) begin
            latest_sync_ticks <= sticks_q;
            latest_sync_time  <= stime_q;
          end
          state <= ST_SYNC_DIFF;
        end
        ST_SYNC_DIFF: begin
          state <= (latest_sync_ticks == TICKS_NONE) ? ST_FINISH : ST_SYNC_WARN;
        end
        ST_SYNC_WARN: begin
          state <= local_ahead ? ST_SYNC_MUL : ST_FINISH;
        end
        ST_SYNC_MUL: begin
          if (md_rsp.done) begin
            state <= ST_SYNC_ADD;
          end
        end
        ST_SYNC_ADD: begin
          state <= ST_SYNC_CMP;
        end
        ST_SYNC_CMP: begin
          if (est_newer) begin
            estimate_base_ticks <= est_work;
            estimate_base_time  <= now_q;
          end
          state <= ST_FINISH;
        end
        ST_QRY_ELAPSED: begin
          state <= (estimate_base_ticks == TICKS_NONE) ? ST_FINISH : ST_QRY_MUL;
        end
        ST_QRY_MUL: begin
          if (md_rsp.done) begin
            state <= ST_QRY_ADD;
          end
        end
        ST_QRY_ADD: begin
          state <= ST_QRY_TGT;
        end
        ST_QRY_TGT: begin
          state <= md_req.start ? ST_QRY_DIV : ST_FINISH;
        end
        ST_QRY_DIV: begin
          if (md_rsp.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold here only while the previous result has not been taken.
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_q           <= opcode;
          sticks_q       <= sync_ticks;
          stime_q        <= sync_time_us[TIME_WIDTH-1:0];
          now_q          <= now_us[TIME_WIDTH-1:0];
          target_q       <= target_ticks;
          est_work       <= TICKS_NONE;
          res_wait       <= '0;
          res_updated    <= 1'b0;
          res_early_warn <= 1'b0;
          res_early_by   <= '0;
          res_late_warn  <= 1'b0;
          res_late_by    <= '0;
        end
      end
      ST_SYNC_DIFF: begin
        sync_ahead  <= sub_local_lead[TIME_WIDTH];
        local_ahead <= sub_sync_lead[TIME_WIDTH];
        lead_sync   <= sub_sync_lead[TIME_WIDTH-1:0];
        lead_local  <= sub_local_lead[TIME_WIDTH-1:0];
      end
      ST_SYNC_WARN: begin
        if (sync_ahead && (64'(lead_sync) > 64'(early_margin_us))) begin
          res_early_warn <= 1'b1;
          res_early_by   <= 64'(lead_sync);
        end
        if (local_ahead && (64'(lead_local) > 64'(late_limit_us))) begin
          res_late_warn <= 1'b1;
          res_late_by   <= 64'(lead_local);
        end
      end
      ST_SYNC_ADD: begin
        est_work <= add_est(latest_sync_ticks, md_rsp.q);
      end
      ST_SYNC_CMP: begin
        if (est_newer) begin
          res_updated <= 1'b1;
        end
      end
      ST_QRY_ADD: begin
        est_work <= add_est(estimate_base_ticks, md_rsp.q);
      end
      ST_QRY_DIV: begin
        if (md_rsp.done) begin
          res_wait <= md_rsp.q;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_res.estimate_valid <= (fin_ticks != TICKS_NONE);
          out_res.estimate_ticks <= fin_ticks;
          out_res.wait_us        <= res_wait;
          out_res.updated        <= res_updated;
          out_res.early_warn     <= res_early_warn;
          out_res.early_by_us    <= res_early_by;
          out_res.late_warn      <= res_late_warn;
          out_res.late_by_us     <= res_late_by;
        end
      end
      default: ;
    endcase
  end

  assign estimate_valid = out_res.estimate_valid;
  assign estimate_ticks = out_res.estimate_ticks;
  assign wait_us        = out_res.wait_us;
  assign updated        = out_res.updated;
  assign early_warn     = out_res.early_warn;
  assign early_by_us    = out_res.early_by_us;
  assign late_warn      = out_res.late_warn;
  assign late_by_us     = out_res.late_by_us;

endmodule

`default_nettype wire

// ===== src/tse_checker.sv =====
// Port-level checks for the timestamp estimator core, and the bind that
// attaches them to it. Depends only on the core's port names.
`default_nettype none

module tse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        estimate_valid,
  input logic [63:0] estimate_ticks,
  input logic [63:0] wait_us,
  input logic        updated,
  input logic        early_warn,
  input logic [63:0] early_by_us,
  input logic        late_warn,
  input logic [63:0] late_by_us
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(estimate_ticks) && $stable(wait_us))
    else $error("stalled result changed or dropped");

  // The valid flag and the all-ones "no estimate" pattern always agree.
  a_valid_pattern: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> estimate_valid == (estimate_ticks != 64'hFFFF_FFFF_FFFF_FFFF))
    else $error("estimate_valid disagrees with estimate_ticks");

  // Without an estimate there is nothing to wait for and nothing was stored.
  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !estimate_valid |-> wait_us == 64'd0 && !updated)
    else $error("result without estimate carries a wait or an update");

  // Amounts are zero unless their warning is raised, and both never fire.
  a_warn_amounts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (early_warn || early_by_us == 64'd0) && (late_warn || late_by_us == 64'd0)
                  && !(early_warn && late_warn))
    else $error("warning amount without warning, or both warnings raised");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule

bind timesync_timestamp_estimator_core tse_checker u_tse_checker (.*);

`default_nettype wire
